### rtl/tcrl_pkg.sv
// Package for the timestamped cursor ring lookup core.
// Holds the item structs, mode codes and default ring depth; no dependencies.
`default_nettype none
package tcrl_pkg;

	localparam int RingDepthDefault = 16384;
	localparam int PosW = 48;
	localparam int IdxW = 15;
	localparam int EpochW = 16;
	localparam int FracW = 16;

	typedef enum logic [1:0] {
		MODE_CAPTURE   = 2'd0,
		MODE_NEW_EPOCH = 2'd1,
		MODE_QUERY     = 2'd2,
		MODE_UNUSED    = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]      mode;
		logic [PosW-1:0] sample_position;
		logic [IdxW-1:0] order_number;
		logic [IdxW-1:0] row_number;
		logic [PosW-1:0] played_position;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic signed [15:0] order_out;
		logic signed [15:0] row_out;
		logic [EpochW-1:0]  heard_epoch;
		logic [FracW-1:0]   row_fraction;
	} out_item_t;

endpackage
`default_nettype wire

### rtl/timestamped_cursor_ring_lookup_core.sv
// Capture and new-epoch items give no result. A query runs a backward scan for the heard
// entry, a backward walk to the row start and a forward walk to the row end, reading the
// ring through a single registered memory port, then runs a shift-subtract divide.
// One item at a time; the result waits in an output register. Reset clears the control
// state at once; ring contents stay undefined until written.
// Depends on tcrl_pkg.
`default_nettype none
module timestamped_cursor_ring_lookup_core #(
	parameter int RING_DEPTH = tcrl_pkg::RingDepthDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire tcrl_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output tcrl_pkg::out_item_t      out_data
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = AW + 1;
	localparam int PW = tcrl_pkg::PosW;
	localparam int IW = tcrl_pkg::IdxW;
	localparam int EW = tcrl_pkg::EpochW;
	localparam int EntW = PW + 2 * IW + EW;
	localparam int DW = PW + 16;
	localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_WRITE = 9'b000000010,
		ST_FIND  = 9'b000000100,
		ST_FINDW = 9'b000001000,
		ST_BACK  = 9'b000010000,
		ST_FWD   = 9'b000100000,
		ST_DIV   = 9'b001000000,
		ST_DONE  = 9'b010000000,
		ST_WAIT  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic [PW-1:0] pos;
		logic [IW-1:0] ord;
		logic [IW-1:0] row;
		logic [EW-1:0] ep;
	} entry_t;

	entry_t        mem [RING_DEPTH];
	entry_t        rd_q;
	logic [AW-1:0] rd_addr;
	logic          mem_we;

	state_t        state_q;
	tcrl_pkg::in_item_t item_q;
	logic [AW-1:0] wslot_q;
	logic [CW-1:0] fill_q;
	logic [EW-1:0] live_q;
	logic [EW-1:0] heard_q;
	logic [CW-1:0] k_q;
	logic          pend_q;
	entry_t        cur_q;
	logic [PW-1:0] start_q;
	logic [PW-1:0] next_q;
	logic          have_next_q;
	logic [DW-1:0] quo_q;
	logic [PW:0]   rem_q;
	logic [PW-1:0] den_q;
	logic [6:0]    cnt_q;
	tcrl_pkg::out_item_t res_q;
	tcrl_pkg::out_item_t out_q;
	logic          out_valid_q;

	logic [CW-1:0] oldest_w;
	logic [CW-1:0] kslot_w;
	logic [AW-1:0] oldest;
	logic [AW-1:0] kslot;
	logic [PW:0]   rem_sh;
	logic          same;

	assign oldest_w = (fill_q > CW'(wslot_q)) ? CW'(wslot_q) + DEPTH_C - fill_q
		: CW'(wslot_q) - fill_q;
	assign oldest = oldest_w[AW-1:0];
	assign kslot_w = CW'(oldest) + k_q;
	assign kslot = (kslot_w >= DEPTH_C) ? AW'(kslot_w - DEPTH_C) : kslot_w[AW-1:0];
	assign mem_we = (state_q == ST_WRITE) &&
		(item_q.mode == tcrl_pkg::MODE_CAPTURE);
	assign rd_addr = kslot;
	assign same = (rd_q.ep == cur_q.ep) && (rd_q.ord == cur_q.ord) && (rd_q.row == cur_q.row);
	assign rem_sh = {rem_q[PW-1:0], quo_q[DW-1]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wslot_q] <= {item_q.sample_position, item_q.order_number,
				item_q.row_number, live_q};
		end
		rd_q <= mem[rd_addr];
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wslot_q <= '0;
			fill_q <= '0;
			live_q <= '0;
			heard_q <= '0;
			out_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_WAIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					priority if (item_q.mode == tcrl_pkg::MODE_CAPTURE) begin
						wslot_q <= (CW'(wslot_q) + 1'b1 == DEPTH_C) ? '0 : wslot_q + 1'b1;
						if (fill_q != DEPTH_C) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end else if (item_q.mode == tcrl_pkg::MODE_NEW_EPOCH) begin
						live_q <= live_q + 1'b1;
						state_q <= ST_IDLE;
					end else if (item_q.mode == tcrl_pkg::MODE_QUERY) begin
						if (fill_q == '0) begin
							res_q <= '{found: 1'b0, order_out: -16'sd1, row_out: -16'sd1,
								heard_epoch: heard_q, row_fraction: '0};
							state_q <= ST_WAIT;
						end else begin
							k_q <= fill_q - 1'b1;
							pend_q <= 1'b0;
							state_q <= ST_FIND;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIND: begin
					// rd_q holds the entry of the rank addressed in the previous cycle.
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (rd_q.pos <= item_q.played_position || k_q == fill_q) begin
						// k_q ran one past; entry found at k_q+1, or fell back to oldest.
						if (k_q == fill_q) begin
							k_q <= '0;
						end else begin
							k_q <= k_q + 1'b1;
						end
						pend_q <= 1'b0;
						state_q <= ST_FINDW;
					end
					if (pend_q && !(rd_q.pos <= item_q.played_position) && k_q != fill_q) begin
						k_q <= (k_q == '0) ? fill_q : k_q - 1'b1;
					end else if (!pend_q) begin
						k_q <= (k_q == '0) ? fill_q : k_q - 1'b1;
					end
				end
				ST_FINDW: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else begin
						cur_q <= rd_q;
						start_q <= rd_q.pos;
						heard_q <= rd_q.ep;
						have_next_q <= 1'b0;
						item_q.sample_position <= PW'(k_q);
						pend_q <= 1'b0;
						if (k_q == '0) begin
							state_q <= ST_FWD;
							k_q <= k_q + 1'b1;
						end else begin
							k_q <= k_q - 1'b1;
							state_q <= ST_BACK;
						end
					end
				end
				ST_BACK: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (same && k_q != '0) begin
						start_q <= rd_q.pos;
						k_q <= k_q - 1'b1;
						pend_q <= 1'b0;
					end else begin
						if (same) begin
							start_q <= rd_q.pos;
						end
						k_q <= CW'(item_q.sample_position) + 1'b1;
						have_next_q <= 1'b0;
						pend_q <= 1'b0;
						state_q <= ST_FWD;
					end
				end
				ST_FWD: begin
					if (k_q >= fill_q) begin
						state_q <= ST_DIV;
						cnt_q <= '0;
					end else if (!pend_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (rd_q.ep != cur_q.ep) begin
							k_q <= fill_q;
						end else if (!same) begin
							next_q <= rd_q.pos;
							have_next_q <= 1'b1;
							k_q <= fill_q;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
					if (k_q >= fill_q) begin
						quo_q <= {item_q.played_position - start_q, 16'h0};
						rem_q <= '0;
						den_q <= next_q - start_q;
					end
				end
				ST_DIV: begin
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= rem_sh - {1'b0, den_q};
						quo_q <= {quo_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[DW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'(DW - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					res_q.found <= 1'b1;
					res_q.order_out <= 16'(cur_q.ord);
					res_q.row_out <= 16'(cur_q.row);
					res_q.heard_epoch <= cur_q.ep;
					if (have_next_q && next_q > start_q && item_q.played_position >= start_q) begin
						res_q.row_fraction <= (quo_q[DW-1:16] != '0) ? 16'hFFFF : quo_q[15:0];
					end else begin
						res_q.row_fraction <= '0;
					end
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!out_valid_q || out_ready) begin
						out_q <= res_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
